// ----- rtl/sdspi_pkg.sv -----
// ----------------------------------------------------------------------------
// sdspi_pkg: shared types and constants
// Phase codes, command codes, status codes and command frame helpers.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  localparam int unsigned BlockBytesDefault = 512;
  localparam int unsigned CntW = 11;

  // host command codes
  localparam logic [2:0] CMD_INIT  = 3'd0;
  localparam logic [2:0] CMD_READ  = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_CARD  = 3'd3;
  localparam logic [2:0] CMD_WBYTE = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RST_TO   = 3'd1;
  localparam logic [2:0] ST_VOLT     = 3'd2;
  localparam logic [2:0] ST_APP_REJ  = 3'd3;
  localparam logic [2:0] ST_CMD_REJ  = 3'd4;
  localparam logic [2:0] ST_WR_REJ   = 3'd5;

  // card command indexes
  localparam logic [5:0] IDX_GO_IDLE = 6'd0;
  localparam logic [5:0] IDX_IF_COND = 6'd8;
  localparam logic [5:0] IDX_READ    = 6'd17;
  localparam logic [5:0] IDX_WRITE   = 6'd24;
  localparam logic [5:0] IDX_OP_COND = 6'd41;
  localparam logic [5:0] IDX_APP     = 6'd55;
  localparam logic [5:0] IDX_OCR     = 6'd58;

  localparam logic [7:0] BYTE_IDLE  = 8'hFF;
  localparam logic [7:0] TOKEN_DATA = 8'hFE;
  localparam logic [7:0] CRC_CMD0   = 8'h95;
  localparam logic [7:0] CRC_CMD8   = 8'h87;
  localparam logic [7:0] CHECK_PAT  = 8'hAA;
  localparam logic [7:0] HCS_BIT    = 8'h40;
  localparam logic [7:0] CMD_START  = 8'b0100_0000;
  localparam logic [7:0] RESP_MASK  = 8'h0E;
  localparam logic [2:0] RESP_OK    = 3'd2;

  typedef enum logic [17:0] {
    PH_IDLE        = 18'h00001,
    PH_INIT_CLOCKS = 18'h00002,
    PH_CMD_SEND    = 18'h00004,
    PH_CMD_POLL    = 18'h00008,
    PH_CMD_EXTRA   = 18'h00010,
    PH_CMD_BUSY    = 18'h00020,
    PH_RD_TOKEN    = 18'h00040,
    PH_RD_DATA     = 18'h00080,
    PH_RD_CRC      = 18'h00100,
    PH_RD_TAIL     = 18'h00200,
    PH_WR_GAP      = 18'h00400,
    PH_WR_TOKEN    = 18'h00800,
    PH_WR_NEED     = 18'h01000,
    PH_WR_DATA     = 18'h02000,
    PH_WR_CRC      = 18'h04000,
    PH_WR_RESP     = 18'h08000,
    PH_WR_BUSY     = 18'h10000,
    PH_WR_TAIL     = 18'h20000
  } phase_t;

  typedef struct packed {
    logic [7:0] send_byte;
    logic       send_request;
    logic       select_active;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       want_write_byte;
    logic       done_res;
    logic [2:0] status;
    logic       high_capacity;
  } result_t;

  // command frame byte k of command idx
  function automatic logic [7:0] frame_byte(input logic [5:0] idx, input logic [2:0] k,
                                            input logic [31:0] addr);
    logic [7:0] b;
    b = 8'h00;
    if (k == 3'd0) b = CMD_START | {2'b00, idx};
    else if (k == 3'd5) b = (idx == IDX_GO_IDLE) ? CRC_CMD0 :
                            ((idx == IDX_IF_COND) ? CRC_CMD8 : 8'h00);
    else if (idx == IDX_READ || idx == IDX_WRITE) begin
      case (k)
        3'd1:    b = addr[31:24];
        3'd2:    b = addr[23:16];
        3'd3:    b = addr[15:8];
        default: b = addr[7:0];
      endcase
    end else if (idx == IDX_IF_COND) b = (k == 3'd3) ? 8'h01 : ((k == 3'd4) ? CHECK_PAT : 8'h00);
    else if (idx == IDX_OP_COND) b = (k == 3'd1) ? HCS_BIT : 8'h00;
    return b;
  endfunction

endpackage

// ----- rtl/sdspi_core.sv -----
// ----------------------------------------------------------------------------
// sdspi_core: protocol state and next-step logic
// Holds the engine state and works out one result per accepted item.
// ----------------------------------------------------------------------------
module sdspi_core import sdspi_pkg::*; #(
  parameter int unsigned BLOCK_BYTES = BlockBytesDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [2:0]  command,
  input  logic [31:0] block_number,
  input  logic [7:0]  card_byte,
  input  logic [7:0]  write_byte,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output result_t     res
);

  localparam logic [CntW-1:0] BlkLast = CntW'(BLOCK_BYTES);

  phase_t          phase_r, phase_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [15:0]     try_r, try_nxt;
  logic [7:0]      rb_r [5];
  logic [7:0]      rb_nxt [5];
  logic [31:0]     addr_r, addr_nxt;
  logic [5:0]      idx_r, idx_nxt;
  logic            cap_r, cap_nxt;
  logic [7:0]      rlim_r;
  logic [15:0]     xlim_r;

  // combinational step
  always_comb begin
    logic [CntW-1:0] c1;
    logic [5:0]      nx;
    logic            start, fin, longr;
    logic [2:0]      st;
    logic [7:0]      r0;
    phase_nxt = phase_r; cnt_nxt = cnt_r; try_nxt = try_r; addr_nxt = addr_r;
    idx_nxt = idx_r; cap_nxt = cap_r;
    for (int i = 0; i < 5; i++) rb_nxt[i] = rb_r[i];
    res = '0;
    c1 = cnt_r + 1'b1;
    nx = IDX_GO_IDLE; start = 1'b0; fin = 1'b0; st = ST_OK;
    longr = (idx_r == IDX_IF_COND) || (idx_r == IDX_OCR);
    r0 = rb_r[0];
    case (command)
      CMD_INIT, CMD_READ, CMD_WRITE: begin
        if (phase_r == PH_IDLE) begin
          addr_nxt = block_number;
          if (command == CMD_INIT) begin
            cnt_nxt = '0; try_nxt = '0; phase_nxt = PH_INIT_CLOCKS;
            res.send_byte = BYTE_IDLE; res.send_request = 1'b1;
          end else begin
            start = 1'b1; nx = (command == CMD_READ) ? IDX_READ : IDX_WRITE;
          end
        end
      end
      CMD_WBYTE: begin
        if (phase_r == PH_WR_NEED) begin
          phase_nxt = PH_WR_DATA;
          res.send_byte = write_byte; res.send_request = 1'b1; res.select_active = 1'b1;
        end
      end
      CMD_CARD: begin
        // decide whether the poll is over, and whether the command completes
        logic endp, after, tryrst, rsel;
        logic [7:0] rq;
        endp = 1'b0; after = 1'b0; tryrst = 1'b0; rsel = 1'b0; rq = BYTE_IDLE;
        case (phase_r)
          PH_INIT_CLOCKS: begin
            cnt_nxt = c1;
            if (c1 < CntW'(10)) begin rsel = 1'b1; rq = BYTE_IDLE; end
            else begin try_nxt = '0; tryrst = 1'b1; end
          end
          PH_CMD_SEND: begin
            cnt_nxt = c1;
            if (c1 < CntW'(6)) begin
              res.send_request = 1'b1; res.select_active = 1'b1;
              res.send_byte = frame_byte(idx_r, c1[2:0], addr_r);
            end else begin
              rb_nxt[0] = BYTE_IDLE; r0 = BYTE_IDLE; cnt_nxt = '0; phase_nxt = PH_CMD_POLL;
              if (rlim_r == 8'd0) endp = 1'b1;
              else begin res.send_request = 1'b1; res.select_active = 1'b1;
                res.send_byte = BYTE_IDLE; end
            end
          end
          PH_CMD_POLL: begin
            rb_nxt[0] = card_byte; r0 = card_byte; cnt_nxt = c1;
            if (!card_byte[7] || c1 >= {3'b000, rlim_r}) endp = 1'b1;
            else begin res.send_request = 1'b1; res.select_active = 1'b1;
              res.send_byte = BYTE_IDLE; end
          end
          PH_CMD_EXTRA: begin
            if (cnt_r < CntW'(5)) rb_nxt[cnt_r[2:0]] = card_byte;
            cnt_nxt = c1;
            if (c1 >= (longr ? CntW'(5) : CntW'(1))) phase_nxt = PH_CMD_BUSY;
            res.send_request = 1'b1; res.select_active = 1'b1; res.send_byte = BYTE_IDLE;
          end
          PH_CMD_BUSY: begin
            if (card_byte != 8'd0) after = 1'b1;
            else begin res.send_request = 1'b1; res.select_active = 1'b1;
              res.send_byte = BYTE_IDLE; end
          end
          PH_RD_TOKEN: begin
            if (card_byte == TOKEN_DATA) begin cnt_nxt = '0; phase_nxt = PH_RD_DATA; end
            res.send_request = 1'b1; res.select_active = 1'b1; res.send_byte = BYTE_IDLE;
          end
          PH_RD_DATA: begin
            res.data_byte = card_byte; res.data_valid = 1'b1; cnt_nxt = c1;
            if (c1 >= BlkLast) begin cnt_nxt = '0; phase_nxt = PH_RD_CRC; end
            res.send_request = 1'b1; res.select_active = 1'b1; res.send_byte = BYTE_IDLE;
          end
          PH_RD_CRC: begin
            cnt_nxt = c1;
            if (c1 >= CntW'(2)) phase_nxt = PH_RD_TAIL;
            res.send_request = 1'b1; res.select_active = 1'b1; res.send_byte = BYTE_IDLE;
          end
          PH_RD_TAIL, PH_WR_TAIL: begin fin = 1'b1; st = ST_OK; end
          PH_WR_GAP: begin
            phase_nxt = PH_WR_TOKEN;
            res.send_request = 1'b1; res.select_active = 1'b1; res.send_byte = TOKEN_DATA;
          end
          PH_WR_TOKEN: begin
            cnt_nxt = '0; phase_nxt = PH_WR_NEED; res.want_write_byte = 1'b1;
          end
          PH_WR_DATA: begin
            cnt_nxt = c1;
            if (c1 < BlkLast) begin phase_nxt = PH_WR_NEED; res.want_write_byte = 1'b1; end
            else begin
              cnt_nxt = '0; phase_nxt = PH_WR_CRC;
              res.send_request = 1'b1; res.select_active = 1'b1; res.send_byte = 8'h00;
            end
          end
          PH_WR_CRC: begin
            cnt_nxt = c1;
            res.send_request = 1'b1; res.select_active = 1'b1;
            if (c1 < CntW'(2)) res.send_byte = 8'h00;
            else begin phase_nxt = PH_WR_RESP; res.send_byte = BYTE_IDLE; end
          end
          PH_WR_RESP: begin
            if (((card_byte & RESP_MASK) >> 1) != {5'd0, RESP_OK}) begin
              fin = 1'b1; st = ST_WR_REJ;
            end else begin
              phase_nxt = PH_WR_BUSY;
              res.send_request = 1'b1; res.select_active = 1'b1; res.send_byte = BYTE_IDLE;
            end
          end
          PH_WR_BUSY: begin
            if (card_byte != 8'd0) phase_nxt = PH_WR_TAIL;
            res.send_request = 1'b1; res.select_active = 1'b1; res.send_byte = BYTE_IDLE;
          end
          default: ;
        endcase
        if (rsel) begin res.send_request = 1'b1; res.send_byte = rq; end
        // end of response poll
        if (endp) begin
          if (r0[7] || (idx_r == IDX_GO_IDLE && !r0[0])) after = 1'b1;
          else if (longr) begin
            cnt_nxt = CntW'(1); phase_nxt = PH_CMD_EXTRA;
            res.send_request = 1'b1; res.select_active = 1'b1; res.send_byte = BYTE_IDLE;
          end else begin
            phase_nxt = PH_CMD_BUSY;
            res.send_request = 1'b1; res.select_active = 1'b1; res.send_byte = BYTE_IDLE;
          end
        end
        // command completion
        if (after) begin
          case (idx_r)
            IDX_GO_IDLE: begin
              try_nxt = try_r + 1'b1;
              if (r0 == 8'h01) begin start = 1'b1; nx = IDX_IF_COND; end
              else tryrst = 1'b1;
            end
            IDX_IF_COND: begin
              if (r0 == 8'h01 && !(rb_r[1] == 8'h00 && rb_r[2] == 8'h00 &&
                  rb_r[3] == 8'h01 && rb_r[4] == CHECK_PAT)) begin fin = 1'b1; st = ST_VOLT; end
              else begin start = 1'b1; nx = (r0 != 8'h00) ? IDX_APP : IDX_OCR; end
            end
            IDX_APP: begin
              if (r0 != 8'h01) begin fin = 1'b1; st = ST_APP_REJ; end
              else begin start = 1'b1; nx = IDX_OP_COND; end
            end
            IDX_OP_COND: begin start = 1'b1; nx = (r0 != 8'h00) ? IDX_APP : IDX_OCR; end
            IDX_OCR: begin cap_nxt = rb_r[1][6]; fin = 1'b1; st = ST_OK; end
            IDX_READ, IDX_WRITE: begin
              if (r0 != 8'h00) begin fin = 1'b1; st = ST_CMD_REJ; end
              else begin
                phase_nxt = (idx_r == IDX_READ) ? PH_RD_TOKEN : PH_WR_GAP;
                res.send_request = 1'b1; res.select_active = 1'b1; res.send_byte = BYTE_IDLE;
              end
            end
            default: begin fin = 1'b1; st = ST_OK; end
          endcase
        end
        if (tryrst) begin
          if (try_nxt >= xlim_r) begin fin = 1'b1; st = ST_RST_TO; end
          else begin start = 1'b1; nx = IDX_GO_IDLE; end
        end
      end
      default: ;
    endcase
    if (start) begin
      idx_nxt = nx; cnt_nxt = '0; phase_nxt = PH_CMD_SEND;
      for (int i = 0; i < 5; i++) rb_nxt[i] = 8'h00;
      res.send_request = 1'b1; res.select_active = 1'b1;
      res.send_byte = CMD_START | {2'b00, nx};
    end
    if (fin) begin phase_nxt = PH_IDLE; res.done_res = 1'b1; res.status = st; end
    res.high_capacity = cap_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; cnt_r <= '0; try_r <= '0; addr_r <= '0;
      idx_r <= '0; cap_r <= 1'b0; rlim_r <= 8'd8; xlim_r <= 16'd100;
    end else begin
      if (step) begin
        phase_r <= phase_nxt; cnt_r <= cnt_nxt; try_r <= try_nxt;
        addr_r <= addr_nxt; idx_r <= idx_nxt; cap_r <= cap_nxt;
      end
      if (cfg_we) begin
        if (cfg_index) xlim_r <= cfg_data;
        else rlim_r <= cfg_data[7:0];
      end
    end
  end

  // response bytes
  always_ff @(posedge clk) begin
    if (step) for (int i = 0; i < 5; i++) rb_r[i] <= rb_nxt[i];
  end

endmodule

// ----- rtl/sd_card_spi_host_engine.sv -----
// ----------------------------------------------------------------------------
// sd_card_spi_host_engine: SD card SPI-mode host engine
// Turns host requests and card bytes into SPI exchange requests and results.
// ----------------------------------------------------------------------------
// Usage: the host sends items on the in_ channel: initialize, read block,
// write block, a card byte after each requested exchange, or a write byte when
// asked. Every accepted item gives exactly one result item on out_, holding
// the next exchange request, read data, write-byte request and completion.
// Results are registered in out_r, or in skid_r on a stall; one item per
// cycle is taken while in_tready is high, as the step is one state-logic pass.
// A one-entry output register with a skid stage lets a new item in while a
// result waits; when the receiver stalls, both fill and in_tready drops.
// Reset (rst_n low, synchronous) idles the engine, clears capacity and sets try
// limits to 8 response polls and 100 reset attempts. Configuration writes are
// taken at once; the user is to make them while idle, which the block does not check.
// ----------------------------------------------------------------------------
module sd_card_spi_host_engine import sdspi_pkg::*; #(
  parameter int unsigned BLOCK_BYTES = BlockBytesDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // block_number[31:0], card_byte[39:32], write_byte[47:40]
  input  logic [47:0] in_tdata,
  // command[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // send_byte[7:0], send_request[8], select_active[9], data_byte[17:10],
  // data_valid[18], want_write_byte[19], done_res[20], status[23:21],
  // high_capacity[24]
  output logic [31:0] out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata
);

  result_t res, out_r, skid_r;
  logic    ov_r, sv_r, step;

  assign in_tready = !sv_r;
  assign step = in_tvalid && in_tready;

  sdspi_core #(.BLOCK_BYTES(BLOCK_BYTES)) u_core (
    .clk, .rst_n, .step,
    .command(in_tuser), .block_number(in_tdata[31:0]),
    .card_byte(in_tdata[39:32]), .write_byte(in_tdata[47:40]),
    .cfg_we, .cfg_index(cfg_addr), .cfg_data(cfg_wdata), .res
  );

  // output register and skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0; sv_r <= 1'b0;
    end else begin
      if (!ov_r || out_tready) begin
        ov_r <= sv_r || step;
        sv_r <= 1'b0;
      end else if (step) begin
        sv_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!ov_r || out_tready) out_r <= sv_r ? skid_r : res;
    if (step && ov_r && !out_tready) skid_r <= res;
  end

  // result fields packed from the lowest bit up
  assign out_tvalid = ov_r;
  assign out_tdata  = {7'd0, out_r.high_capacity, out_r.status, out_r.done_res,
                       out_r.want_write_byte, out_r.data_valid, out_r.data_byte,
                       out_r.select_active, out_r.send_request, out_r.send_byte};

endmodule
